// ===== rtl/core/med3x3_pkg.sv =====
package med3x3_pkg;

    localparam int PIX_W      = 8;
    localparam int LW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [2:0]     trio_t;
    typedef logic             cfg_addr_t;

    localparam cfg_addr_t CFG_LINE_WIDTH   = 1'b0;
    localparam cfg_addr_t CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } mark_t;

    // ascending: [0] lowest, [2] highest
    function automatic trio_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t lo;
        pixel_t hi;
        pixel_t m;
        trio_t  r;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        m    = (hi < c) ? hi : c;
        r[2] = (hi < c) ? c : hi;
        r[0] = (lo < m) ? lo : m;
        r[1] = (lo < m) ? m : lo;
        return r;
    endfunction

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t lo;
        pixel_t hi;
        pixel_t t;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        t  = (hi < c) ? hi : c;
        return (lo < t) ? t : lo;
    endfunction

    function automatic pixel_t max3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t t;
        t = (a < b) ? b : a;
        return (t < c) ? c : t;
    endfunction

    function automatic pixel_t min3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t t;
        t = (a < b) ? a : b;
        return (c < t) ? c : t;
    endfunction

endpackage

// ===== rtl/core/median_3x3_image_filter_unit.sv =====
// 3x3 median filter for an 8-bit grayscale pixel stream.
// s_ channel: one pixel per beat in raster order. m_ channel: one beat per
// pixel whose 3x3 window is complete (column >= 2 and row >= 2), carrying
// the median for position (row-2, col-2); m_tlast marks the last result of
// a row, m_tuser the last result of the frame.
// Configuration: cfg_addr selects line width or frame height; a write
// restarts the frame at row 0, column 0. Write only while the block is idle.
// Throughput: one pixel per cycle sustained while m_tready is high. An accepted
// pixel passes through the line store read, column sort, merge of the sorted
// columns and the output register before its result is on m_tdata.
// The two previous rows live in one dual-port line RAM (one read, one write
// per cycle); each pixel reads its column and writes it back when it leaves
// the read stage, so consecutive pixels never touch the same entry.
// When m_tready is low the pipeline keeps filling its empty stages and
// then holds s_tready low; nothing is dropped.
// Reset clears the counters, the window and all valid flags; the width and
// height return to 512 (width limited to MAX_WIDTH). Line RAM contents are
// not cleared; no result of a frame uses an entry it has not written itself.
module median_3x3_image_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  med3x3_pkg::pixel_t                    s_tdata,   // [7:0] pixel_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output med3x3_pkg::pixel_t                    m_tdata,   // [7:0] median_value
    output logic                                  m_tlast,   // out_row_end
    output logic [0:0]                            m_tuser,   // [0] out_frame_end
    input  logic                                  cfg_wr_en,
    input  med3x3_pkg::cfg_addr_t                 cfg_addr,
    input  logic [med3x3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import med3x3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LW_RST = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
    localparam logic [COL_W-1:0] LAST_COL_RST = COL_W'(LW_RST - 1);
    localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(511);

    // configuration, stored as last column / last row index
    logic [COL_W-1:0] last_col_reg;
    logic [COL_W-1:0] last_col_next;
    logic [ROW_W-1:0] last_row_reg;
    logic [ROW_W-1:0] last_row_next;
    logic [LW_W-1:0]  lw_val;
    logic [FH_W-1:0]  fh_val;
    logic [FH_W-1:0]  fh_m1;
    logic [COL_W-1:0] lw_clamped;
    logic [ROW_W-1:0] fh_clamped;

    // position of the next input pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // read stage: pixel whose line RAM data is on ram_rd_data
    logic             a_valid_reg;
    logic             a_valid_next;
    pixel_t           a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic             a_emit_reg;
    mark_t            a_mark_reg;

    pixel_t win_reg [6];

    logic       s_take;
    logic       a_leave;
    logic       in_emit;
    mark_t      in_mark;
    logic [15:0] ram_rd_data;
    pixel_t     top_pix;
    pixel_t     mid_pix;

    logic             srt_in_valid;
    logic             srt_in_ready;
    pixel_t [8:0]     srt_pix;
    logic             srt_out_valid;
    pixel_t           srt_median;
    mark_t            srt_mark;

    logic   o_valid_reg;
    logic   o_valid_next;
    logic   o_ready;
    pixel_t o_med_reg;
    mark_t  o_mark_reg;

    assign top_pix = ram_rd_data[15:8];
    assign mid_pix = ram_rd_data[7:0];

    // configuration clamping
    assign lw_val = cfg_wdata[LW_W-1:0];
    assign fh_val = cfg_wdata[FH_W-1:0];
    assign fh_m1  = fh_val - FH_W'(1);

    always_comb begin
        if (lw_val < LW_W'(3)) begin
            lw_clamped = COL_W'(2);
        end else if (32'(lw_val) > MAX_WIDTH) begin
            lw_clamped = COL_W'(MAX_WIDTH - 1);
        end else begin
            lw_clamped = COL_W'(lw_val - LW_W'(1));
        end
        if (fh_val < FH_W'(3)) begin
            fh_clamped = ROW_W'(2);
        end else if (32'(fh_val) > MAX_HEIGHT) begin
            fh_clamped = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            fh_clamped = fh_m1[ROW_W-1:0];
        end
    end

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LINE_WIDTH:   last_col_next = lw_clamped;
                CFG_FRAME_HEIGHT: last_row_next = fh_clamped;
            endcase
        end
    end

    // handshake chain
    assign o_ready      = !o_valid_reg || m_tready;
    assign a_leave      = a_valid_reg && (!a_emit_reg || srt_in_ready);
    assign s_tready     = !a_valid_reg || a_leave;
    assign s_take       = s_tvalid && s_tready;
    assign srt_in_valid = a_valid_reg && a_emit_reg;

    assign in_emit           = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
    assign in_mark.row_end   = (col_reg == last_col_reg);
    assign in_mark.frame_end = (col_reg == last_col_reg) && (row_reg == last_row_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (s_take) begin
            if (in_mark.row_end) begin
                col_next = '0;
                row_next = in_mark.frame_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_tready) begin
            a_valid_next = s_tvalid;
        end
        o_valid_next = o_valid_reg;
        if (o_ready) begin
            o_valid_next = srt_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= LAST_COL_RST;
            last_row_reg <= LAST_ROW_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            a_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            a_valid_reg  <= a_valid_next;
            o_valid_reg  <= o_valid_next;
            // window slides by one column as each pixel leaves the read stage
            if (a_leave) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_pix;
                win_reg[4] <= mid_pix;
                win_reg[5] <= a_pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_pix_reg  <= s_tdata;
            a_col_reg  <= col_reg;
            a_emit_reg <= in_emit;
            a_mark_reg <= in_mark;
        end
        if (o_ready && srt_out_valid) begin
            o_med_reg  <= srt_median;
            o_mark_reg <= srt_mark;
        end
    end

    // line RAM entry: older row in the upper byte, newer row in the lower
    med3x3_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (a_leave),
        .wr_addr (a_col_reg),
        .wr_data ({mid_pix, a_pix_reg}),
        .rd_en   (s_take),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign srt_pix[0] = win_reg[0];
    assign srt_pix[1] = win_reg[1];
    assign srt_pix[2] = win_reg[2];
    assign srt_pix[3] = win_reg[3];
    assign srt_pix[4] = win_reg[4];
    assign srt_pix[5] = win_reg[5];
    assign srt_pix[6] = top_pix;
    assign srt_pix[7] = mid_pix;
    assign srt_pix[8] = a_pix_reg;

    med3x3_sorter u_sorter (
        .clk        (aclk),
        .rst_n      (aresetn),
        .in_valid   (srt_in_valid),
        .in_ready   (srt_in_ready),
        .in_pix     (srt_pix),
        .in_mark    (a_mark_reg),
        .out_valid  (srt_out_valid),
        .out_ready  (o_ready),
        .out_median (srt_median),
        .out_mark   (srt_mark)
    );

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = o_med_reg;
    assign m_tlast    = o_mark_reg.row_end;
    assign m_tuser[0] = o_mark_reg.frame_end;

endmodule

// ===== rtl/core/med3x3_ram.sv =====
module med3x3_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/med3x3_sorter.sv =====
module med3x3_sorter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  med3x3_pkg::pixel_t [8:0]      in_pix,
    input  med3x3_pkg::mark_t             in_mark,
    output logic                          out_valid,
    input  logic                          out_ready,
    output med3x3_pkg::pixel_t            out_median,
    output med3x3_pkg::mark_t             out_mark
);
    import med3x3_pkg::*;

    // stage b: each window column sorted
    logic  b_valid_reg;
    logic  b_valid_next;
    trio_t b_col_reg [3];
    mark_t b_mark_reg;

    // stage c: max of lows, median of middles, min of highs
    logic   c_valid_reg;
    logic   c_valid_next;
    pixel_t c_lo_max_reg;
    pixel_t c_mid_med_reg;
    pixel_t c_hi_min_reg;
    mark_t  c_mark_reg;

    logic c_ready;
    logic b_take;
    logic c_take;

    assign c_ready  = !c_valid_reg || out_ready;
    assign in_ready = !b_valid_reg || c_ready;
    assign b_take   = in_valid && in_ready;
    assign c_take   = b_valid_reg && c_ready;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (in_ready) begin
            b_valid_next = in_valid;
        end
        c_valid_next = c_valid_reg;
        if (c_ready) begin
            c_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (b_take) begin
            for (int k = 0; k < 3; k++) begin
                b_col_reg[k] <= sort3(in_pix[3*k], in_pix[3*k+1], in_pix[3*k+2]);
            end
            b_mark_reg <= in_mark;
        end
        if (c_take) begin
            c_lo_max_reg  <= max3(b_col_reg[0][0], b_col_reg[1][0], b_col_reg[2][0]);
            c_mid_med_reg <= med3(b_col_reg[0][1], b_col_reg[1][1], b_col_reg[2][1]);
            c_hi_min_reg  <= min3(b_col_reg[0][2], b_col_reg[1][2], b_col_reg[2][2]);
            c_mark_reg    <= b_mark_reg;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_median = med3(c_lo_max_reg, c_mid_med_reg, c_hi_min_reg);
    assign out_mark   = c_mark_reg;

endmodule

// ===== sim/median_3x3_image_filter_unit_test.sv =====
module median_3x3_image_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import med3x3_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int COL_W       = $clog2(MAX_W);
    localparam int SETTLE      = 10;
    localparam int STALL_LIMIT = 4000;
    localparam int SMALL_PX    = 800;

    localparam pixel_t MIX_PX [9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
                                      8'h80, 8'h7F, 8'hFE, 8'h0F};

    typedef struct packed {
        pixel_t median;
        logic   row_end;
        logic   frame_end;
    } filt_res_t;

    typedef struct {
        bit                    is_cfg;
        cfg_addr_t             addr;
        logic [CFG_DATA_W-1:0] val;
        pixel_t                px;
        bit                    typed;
        bit                    has_res;
        filt_res_t             res;
    } dir_step_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    pixel_t                s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    pixel_t                m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en;
    cfg_addr_t             cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    median_3x3_image_filter_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // filter state as the block should hold it
    logic [LW_W-1:0]  line_w_reg;
    logic [FH_W-1:0]  frame_h_reg;
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;
    pixel_t           row_m2 [MAX_W];
    pixel_t           row_m1 [MAX_W];
    pixel_t           win_px [6];
    filt_res_t        median_q [$];

    int n_err        = 0;
    int n_in         = 0;
    int n_out        = 0;
    int n_cfg        = 0;
    int tx_gap_pct   = 10;
    int rx_stall_pct = 10;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int active_width();
        int w;
        w = int'(line_w_reg);
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(frame_h_reg);
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // the median is the value with at most four smaller and at least five not larger
    function automatic pixel_t median_of(input pixel_t v [9]);
        int below;
        int at_most;
        for (int i = 0; i < 9; i++) begin
            below   = 0;
            at_most = 0;
            for (int j = 0; j < 9; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) at_most++;
            end
            if (below <= 4 && at_most >= 5) return v[i];
        end
        return v[0];
    endfunction

    task automatic filter_reset();
        line_w_reg  = LW_W'(512);
        frame_h_reg = FH_W'(512);
        col_pos     = '0;
        row_pos     = '0;
        for (int i = 0; i < MAX_W; i++) begin
            row_m2[i] = '0;
            row_m1[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_px[i] = '0;
    endtask

    task automatic filter_pixel(input pixel_t px, input bit enqueue);
        int        w;
        int        h;
        int        c;
        int        r;
        pixel_t    top;
        pixel_t    mid;
        pixel_t    nine [9];
        filt_res_t res;
        w   = active_width();
        h   = active_height();
        c   = int'(col_pos);
        r   = int'(row_pos);
        top = row_m2[c];
        mid = row_m1[c];
        if (c >= 2 && r >= 2 && enqueue) begin
            for (int i = 0; i < 6; i++) nine[i] = win_px[i];
            nine[6]       = top;
            nine[7]       = mid;
            nine[8]       = px;
            res.median    = median_of(nine);
            res.row_end   = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            median_q.push_back(res);
        end
        row_m2[c] = mid;
        row_m1[c] = px;
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top;
        win_px[4] = mid;
        win_px[5] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = COL_W'(c);
        row_pos = ROW_W'(r);
    endtask

    // only between phases: wait for the pipeline to empty, then write
    task automatic write_reg(input cfg_addr_t a, input logic [CFG_DATA_W-1:0] v);
        s_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (a == CFG_LINE_WIDTH) line_w_reg = v[LW_W-1:0];
        else frame_h_reg = v[FH_W-1:0];
        col_pos = '0;
        row_pos = '0;
        n_cfg++;
    endtask

    task automatic send_pixel(input pixel_t px, input bit by_model,
                              input filt_res_t typed_res, input bit typed_has);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
            // now and then hold off until the output side has caught up
            if ($urandom_range(0, 19) == 0)
                while (median_q.size() != 0) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        n_in++;
        filter_pixel(px, by_model);
        if (!by_model && typed_has) median_q.push_back(typed_res);
        @(posedge aclk);
    endtask

    function automatic pixel_t next_px(input pixel_t prev);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2, 3:    return prev + pixel_t'($urandom_range(0, 6)) - 8'd3;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_stream(input int n_px);
        pixel_t px;
        px = pixel_t'($urandom);
        repeat (n_px) begin
            px = next_px(px);
            send_pixel(px, 1'b1, '0, 1'b0);
        end
    endtask

    function automatic int idle_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    function automatic dir_step_t cfg_step(input cfg_addr_t a, input logic [CFG_DATA_W-1:0] v);
        dir_step_t st;
        st        = '{default: '0};
        st.is_cfg = 1'b1;
        st.addr   = a;
        st.val    = v;
        return st;
    endfunction

    function automatic dir_step_t pix_step(input pixel_t px);
        dir_step_t st;
        st    = '{default: '0};
        st.px = px;
        return st;
    endfunction

    function automatic dir_step_t typed_step(input pixel_t px, input bit has, input filt_res_t res);
        dir_step_t st;
        st         = '{default: '0};
        st.px      = px;
        st.typed   = 1'b1;
        st.has_res = has;
        st.res     = res;
        return st;
    endfunction

    // result side
    always @(negedge aclk) begin
        filt_res_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            n_out++;
            if (median_q.size() == 0) begin
                n_err++;
                $error("result beat with nothing expected: median_value %0d", m_tdata);
            end else begin
                want = median_q.pop_front();
                if (m_tdata !== want.median) begin
                    n_err++;
                    $error("median_value: expected %0d, got %0d", want.median, m_tdata);
                end
                if (m_tlast !== want.row_end) begin
                    n_err++;
                    $error("out_row_end: expected %0d, got %0d", want.row_end, m_tlast);
                end
                if (m_tuser[0] !== want.frame_end) begin
                    n_err++;
                    $error("out_frame_end: expected %0d, got %0d", want.frame_end,
                           m_tuser[0]);
                end
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog: too many cycles without a beat or a register write
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("median_3x3_image_filter_unit_test: done, errors");
        $finish;
    end

    initial begin
        dir_step_t dir_tab [$];
        int        w_pick;
        int        h_pick;
        int        n_pick;
        int        mode;
        int        small_px;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_LINE_WIDTH;
        cfg_wdata = '0;
        filter_reset();

        // reset size is 512 wide: two beats, nothing comes out yet
        dir_tab.push_back(typed_step(8'h00, 1'b0, '0));
        dir_tab.push_back(typed_step(8'hFF, 1'b0, '0));
        // width 0 and height 1 both read as 3
        dir_tab.push_back(cfg_step(CFG_LINE_WIDTH, 13'd0));
        dir_tab.push_back(cfg_step(CFG_FRAME_HEIGHT, 13'd1));
        // flat white frame: one result, last of its row and of the frame
        repeat (8) dir_tab.push_back(typed_step(8'hFF, 1'b0, '0));
        dir_tab.push_back(typed_step(8'hFF, 1'b1, {8'hFF, 1'b1, 1'b1}));
        // next frame starts after the wrap, mixed extremes
        foreach (MIX_PX[i]) dir_tab.push_back(pix_step(MIX_PX[i]));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].addr, dir_tab[i].val);
            else
                send_pixel(dir_tab[i].px, !dir_tab[i].typed, dir_tab[i].res,
                           dir_tab[i].has_res);
        end

        // reset size again: the first row gives no results
        write_reg(CFG_LINE_WIDTH, 13'd512);
        write_reg(CFG_FRAME_HEIGHT, 13'd512);
        send_stream(40);

        // all-ones width clamps to the widest line, three-row frames
        write_reg(CFG_LINE_WIDTH, 13'd2047);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        send_stream(40);

        // all-ones height clamps to the tallest frame, on the narrowest line
        write_reg(CFG_LINE_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd8191);
        send_stream(60);

        small_px = 0;
        while (small_px < SMALL_PX) begin
            tx_gap_pct   = idle_rate();
            rx_stall_pct = idle_rate();
            case ($urandom_range(0, 9))
                0:       w_pick = $urandom_range(0, 2);
                1:       w_pick = $urandom_range(13, 40);
                2:       w_pick = ($urandom_range(0, 3) << LW_W) | $urandom_range(3, 12);
                default: w_pick = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_pick = $urandom_range(0, 2);
                1:       h_pick = $urandom_range(11, 20);
                default: h_pick = $urandom_range(3, 10);
            endcase
            mode = $urandom_range(0, 4);
            if (mode != 1) write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(w_pick));
            if (mode != 0) write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_pick));
            n_pick = active_width() * active_height() * $urandom_range(1, 2);
            if ($urandom_range(0, 1) == 0 || n_pick > 400) n_pick = $urandom_range(5, 150);
            send_stream(n_pick);
            small_px += n_pick;
        end

        // closing stretch at full rate on both sides
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_reg(CFG_LINE_WIDTH, 13'd6);
        write_reg(CFG_FRAME_HEIGHT, 13'd4);
        send_stream(100);

        s_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge aclk);
        repeat (4 * SETTLE) @(posedge aclk);

        $display("ran %0d pixels, checked %0d medians, %0d register writes", n_in, n_out, n_cfg);
        $display("small frames up to 40 wide under random stalls, plus the first rows at %s",
                 "the reset size and at clamped widths and heights");
        if (n_err == 0)
            $display("median_3x3_image_filter_unit_test: done, clean");
        else
            $display("median_3x3_image_filter_unit_test: done, errors");
        $finish;
    end

endmodule
